@@ hdl/b64lc_pkg.sv @@
// ----------------------------------------------------------------------------
// b64lc_pkg
// Shared types, codes and helpers for the base64 layout checker.
// ----------------------------------------------------------------------------
`default_nettype none

package b64lc_pkg;

    // default widths of the internal counters
    localparam int DEF_COUNT_BITS = 32;
    localparam int DEF_GROUP_BITS = 16;

    // fixed widths of the result fields
    localparam int GROUPS_OUT_W = 16;
    localparam int LENGTH_OUT_W = 32;

    // stream widths
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 56;

    // check_status codes
    localparam logic [1:0] ST_SCANNING = 2'd0;
    localparam logic [1:0] ST_ENDED    = 2'd1;
    localparam logic [1:0] ST_FAILED   = 2'd2;

    // scanner phase codes: 0..3 position within a group
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_G0  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_G1  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_G2  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_G3  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CR  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_EOB = 3'd5;
    localparam logic [PHASE_W-1:0] PH_END = 3'd6;

    // special characters
    localparam logic [7:0] CH_PAD = 8'h3D;  // '='
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    typedef struct packed {
        logic [LENGTH_OUT_W-1:0] encoded_length;
        logic                    uses_crlf;
        logic [GROUPS_OUT_W-1:0] groups_per_line;
        logic                    complete_if_ended;
        logic [1:0]              check_status;
    } result_t;

    function automatic logic is_b64(input logic [7:0] c);
        logic upper;
        logic lower;
        logic digit;
        upper = (c >= 8'h41) && (c <= 8'h5A);
        lower = (c >= 8'h61) && (c <= 8'h7A);
        digit = (c >= 8'h30) && (c <= 8'h39);
        return upper || lower || digit || (c == 8'h2B) || (c == 8'h2F);
    endfunction

endpackage

`default_nettype wire

@@ hdl/b64lc_scan.sv @@
// ----------------------------------------------------------------------------
// b64lc_scan
// Layout state registers and the per-byte step that updates them and forms
// the result for the byte being handled.
// ----------------------------------------------------------------------------
`default_nettype none

module b64lc_scan
    import b64lc_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int GROUP_BITS = DEF_GROUP_BITS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       first_of_part,
    output result_t         result
);

    logic [PHASE_W-1:0]    phase_reg,       phase_next;
    logic [GROUP_BITS-1:0] line_groups_reg, line_groups_next;
    logic [GROUP_BITS-1:0] cur_groups_reg,  cur_groups_next;
    logic                  crlf_reg,        crlf_next;
    logic                  failed_reg,      failed_next;
    logic [COUNT_BITS-1:0] valid_bytes_reg, valid_bytes_next;
    logic [COUNT_BITS-1:0] bytes_seen_reg,  bytes_seen_next;

    // state as seen by this byte (cleared on first byte of a part)
    logic [PHASE_W-1:0]    ph;
    logic [GROUP_BITS-1:0] lg;
    logic [GROUP_BITS-1:0] cg;
    logic                  crlf;
    logic                  fail;
    logic [COUNT_BITS-1:0] vb;
    logic [COUNT_BITS-1:0] bs;

    logic [COUNT_BITS-1:0] bs_inc;
    logic [GROUP_BITS-1:0] cg_inc;
    logic                  cg_full;
    logic                  b64;
    logic                  do_line_end;
    logic                  do_pad_end;
    logic [GROUP_BITS-1:0] g_sel;

    // result fields clipped to their output widths
    logic [GROUPS_OUT_W-1:0] groups_sat;
    logic [LENGTH_OUT_W-1:0] length_sat;

    always_comb
    begin
        ph   = first_of_part ? PH_G0 : phase_reg;
        lg   = first_of_part ? '0 : line_groups_reg;
        cg   = first_of_part ? '0 : cur_groups_reg;
        crlf = first_of_part ? 1'b0 : crlf_reg;
        fail = first_of_part ? 1'b0 : failed_reg;
        vb   = first_of_part ? '0 : valid_bytes_reg;
        bs   = first_of_part ? '0 : bytes_seen_reg;

        bs_inc  = (bs == '1) ? bs : bs + 1'b1;
        cg_full = (cg == '1);
        cg_inc  = cg + 1'b1;
        b64     = is_b64(data_byte);

        phase_next       = ph;
        line_groups_next = lg;
        cur_groups_next  = cg;
        crlf_next        = crlf;
        failed_next      = fail;
        valid_bytes_next = vb;
        bytes_seen_next  = bs_inc;
        do_line_end      = 1'b0;
        do_pad_end       = 1'b0;

        if (!fail && (ph < PH_END))
        begin
            unique case (ph)
                PH_G0:
                begin
                    if (b64)
                        phase_next = PH_G1;
                    else if (data_byte == CH_CR)
                        phase_next = PH_CR;
                    else if (data_byte == CH_LF)
                        do_line_end = 1'b1;
                    else
                        failed_next = 1'b1;
                end
                PH_G1:
                begin
                    if (b64)
                        phase_next = PH_G2;
                    else
                        failed_next = 1'b1;
                end
                PH_G2:
                begin
                    if (b64)
                        phase_next = PH_G3;
                    else if (data_byte == CH_PAD)
                        phase_next = PH_EOB;
                    else
                        failed_next = 1'b1;
                end
                PH_G3:
                begin
                    valid_bytes_next = bs_inc;
                    if (b64)
                    begin
                        phase_next = PH_G0;
                        if (cg_full)
                            failed_next = 1'b1;
                        else
                            cur_groups_next = cg_inc;
                    end
                    else if (data_byte == CH_PAD)
                        do_pad_end = 1'b1;
                    else
                        failed_next = 1'b1;
                end
                PH_CR:
                begin
                    if (data_byte != CH_LF)
                        failed_next = 1'b1;
                    else if (!crlf && (lg != '0))
                        failed_next = 1'b1;   // CRLF after LF lines
                    else
                    begin
                        crlf_next   = 1'b1;
                        do_line_end = 1'b1;
                    end
                end
                PH_EOB:
                begin
                    if (data_byte != CH_PAD)
                        failed_next = 1'b1;
                    else
                    begin
                        valid_bytes_next = bs_inc;
                        do_pad_end       = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (do_line_end)
        begin
            if (crlf_next && (ph != PH_CR))
                failed_next = 1'b1;           // bare LF after CRLF lines
            else
            begin
                phase_next = PH_G0;
                if (cg < lg)
                    phase_next = PH_END;      // short last line
                else if (lg == '0)
                begin
                    if (cg == '0)
                        failed_next = 1'b1;   // empty first line
                    else
                    begin
                        line_groups_next = cg;
                        cur_groups_next  = '0;
                    end
                end
                else if (cg != lg)
                    failed_next = 1'b1;
                else
                    cur_groups_next = '0;
            end
        end

        if (do_pad_end)
        begin
            phase_next = PH_END;
            if (cg_full)
                failed_next = 1'b1;
            else
            begin
                cur_groups_next = cg_inc;
                if ((cg >= lg) && (lg != '0))
                    failed_next = 1'b1;       // padded line longer than the rest
            end
        end

        g_sel = (line_groups_next != '0) ? line_groups_next : cur_groups_next;
    end

    generate
        if (GROUP_BITS > GROUPS_OUT_W)
        begin : g_grp_sat
            assign groups_sat = (|g_sel[GROUP_BITS-1:GROUPS_OUT_W]) ?
                '1 : g_sel[GROUPS_OUT_W-1:0];
        end
        else
        begin : g_grp_ext
            assign groups_sat = GROUPS_OUT_W'(g_sel);
        end

        if (COUNT_BITS > LENGTH_OUT_W)
        begin : g_len_sat
            assign length_sat =
                (|valid_bytes_next[COUNT_BITS-1:LENGTH_OUT_W]) ?
                '1 : valid_bytes_next[LENGTH_OUT_W-1:0];
        end
        else
        begin : g_len_ext
            assign length_sat = LENGTH_OUT_W'(valid_bytes_next);
        end
    endgenerate

    always_comb
    begin
        if (failed_next)
            result.check_status = ST_FAILED;
        else if (phase_next >= PH_END)
            result.check_status = ST_ENDED;
        else
            result.check_status = ST_SCANNING;

        result.complete_if_ended = !failed_next &&
            ((phase_next >= PH_END) ||
             ((phase_next == PH_G0) && (valid_bytes_next != '0)));
        result.groups_per_line = groups_sat;
        result.uses_crlf       = crlf_next;
        result.encoded_length  = length_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_G0;
            line_groups_reg <= '0;
            cur_groups_reg  <= '0;
            crlf_reg        <= 1'b0;
            failed_reg      <= 1'b0;
            valid_bytes_reg <= '0;
            bytes_seen_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            line_groups_reg <= line_groups_next;
            cur_groups_reg  <= cur_groups_next;
            crlf_reg        <= crlf_next;
            failed_reg      <= failed_next;
            valid_bytes_reg <= valid_bytes_next;
            bytes_seen_reg  <= bytes_seen_next;
        end
    end

    // failure is sticky within a part
    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !first_of_part && failed_reg) |=> failed_reg)
        else $error("failure cleared without a new part");

    // end of data is sticky within a part
    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !first_of_part && (phase_reg == PH_END)) |=> (phase_reg == PH_END))
        else $error("ended phase left without a new part");

    // valid byte count never runs ahead of the bytes seen
    a_valid_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
        valid_bytes_reg <= bytes_seen_reg)
        else $error("valid byte count exceeds bytes seen");

endmodule

`default_nettype wire

@@ hdl/base64_layout_checker_top.sv @@
// ----------------------------------------------------------------------------
// base64_layout_checker_top
// Checks one MIME part body, byte by byte, for clean base64 line layout.
//
// Usage:
//   Input stream (s_*): one body byte per item in s_tdata, s_tuser flags the
//   first byte of a new part and clears all check state before that byte.
//   Output stream (m_*): exactly one result item per input byte, in order,
//   carrying status, the would-be-accepted flag, groups per line, the CRLF
//   flag and the count of valid encoded bytes.
//   A byte passes through the input register, then the result register.
//   Throughput: one byte per cycle, sustained while the receiver takes results.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; after that s_tready drops until
//   the result is taken. s_tready depends on m_tready combinationally.
//   Reset clears both stage valids and all check state; the first result
//   after reset reflects a fresh part even without the first-byte flag.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_layout_checker_top
    import b64lc_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int GROUP_BITS = DEF_GROUP_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [IN_USER_W-1:0]  s_tuser,   // [0] first_of_part

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata    // [1:0] check_status,
                                                  // [2] complete_if_ended,
                                                  // [18:3] groups_per_line,
                                                  // [19] uses_crlf,
                                                  // [51:20] encoded_length,
                                                  // [55:52] zero
);

    localparam int RES_W = $bits(result_t);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg;
    logic                 in_first_reg;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_res_reg;
    result_t              step_res;
    logic                 fire;
    logic                 s_accept;

    // advance the held byte when the result slot is free or being emptied
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    b64lc_scan #(
        .COUNT_BITS (COUNT_BITS),
        .GROUP_BITS (GROUP_BITS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (fire),
        .data_byte     (in_byte_reg),
        .first_of_part (in_first_reg),
        .result        (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg  <= s_tdata[7:0];
            in_first_reg <= s_tuser[0];
        end
        if (fire)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({{(OUT_DATA_W-RES_W){1'b0}}, out_res_reg});

    // input side only stalls behind a full, stalled result slot
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // a byte handled always yields a result in the next cycle
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("handled byte produced no result");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(out_res_reg))
        else $error("pending result changed under stall");

endmodule

`default_nettype wire

@@ sim/base64_layout_checker_top_tb.sv @@
// ----------------------------------------------------------------------------
// base64_layout_checker_top_tb
// Streams MIME part bodies byte by byte into the base64 layout checker and
// compares every result item field by field against an in-bench scanner
// model. Covers directed layouts and random parts under several
// sender/receiver idle mixes.
// ----------------------------------------------------------------------------

module base64_layout_checker_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import b64lc_pkg::*;

    localparam logic [31:0] LEN_MAX   = '1;
    localparam logic [15:0] GROUP_TOP = '1;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    result_t expected_verdicts[$];

    // scanner model state
    logic [PHASE_W-1:0] sc_phase;
    logic [15:0]        sc_line_groups;
    logic [15:0]        sc_cur_groups;
    logic               sc_crlf;
    logic               sc_failed;
    logic [31:0]        sc_valid_len;
    logic [31:0]        sc_seen;

    base64_layout_checker_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // scanner model
    // ------------------------------------------------------------------------
    function automatic void clear_scanner();
        sc_phase       = PH_G0;
        sc_line_groups = '0;
        sc_cur_groups  = '0;
        sc_crlf        = 1'b0;
        sc_failed      = 1'b0;
        sc_valid_len   = '0;
        sc_seen        = '0;
    endfunction

    function automatic bit in_alphabet(logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h2B, 8'h2F};
    endfunction

    function automatic void take_valid();
        sc_valid_len = (sc_seen == LEN_MAX) ? LEN_MAX : sc_seen + 32'd1;
    endfunction

    function automatic bit bump_group();
        if (sc_cur_groups == GROUP_TOP)
            return 1'b0;
        sc_cur_groups = sc_cur_groups + 16'd1;
        return 1'b1;
    endfunction

    function automatic void close_line();
        if (sc_crlf && sc_phase != PH_CR)
        begin
            sc_failed = 1'b1;
            return;
        end
        sc_phase = PH_G0;
        if (sc_cur_groups < sc_line_groups)
        begin
            // short line ends the data
            sc_phase = PH_END;
            return;
        end
        if (sc_line_groups == 0)
        begin
            if (sc_cur_groups == 0)
            begin
                sc_failed = 1'b1;
                return;
            end
            sc_line_groups = sc_cur_groups;
        end
        else if (sc_cur_groups != sc_line_groups)
        begin
            sc_failed = 1'b1;
            return;
        end
        sc_cur_groups = '0;
    endfunction

    function automatic void finish_pad();
        sc_phase = PH_END;
        if (!bump_group())
            sc_failed = 1'b1;
        else if (sc_cur_groups > sc_line_groups && sc_line_groups > 0)
            sc_failed = 1'b1;
    endfunction

    function automatic void scan_char(logic [7:0] c);
        case (sc_phase)
            PH_G0:
                if (in_alphabet(c))
                    sc_phase = PH_G1;
                else if (c == CH_CR)
                    sc_phase = PH_CR;
                else if (c == CH_LF)
                    close_line();
                else
                    sc_failed = 1'b1;
            PH_G1:
                if (in_alphabet(c))
                    sc_phase = PH_G2;
                else
                    sc_failed = 1'b1;
            PH_G2:
                if (in_alphabet(c))
                    sc_phase = PH_G3;
                else if (c == CH_PAD)
                    sc_phase = PH_EOB;
                else
                    sc_failed = 1'b1;
            PH_G3:
            begin
                take_valid();
                if (in_alphabet(c))
                begin
                    sc_phase = PH_G0;
                    if (!bump_group())
                        sc_failed = 1'b1;
                end
                else if (c == CH_PAD)
                    finish_pad();
                else
                    sc_failed = 1'b1;
            end
            PH_CR:
                if (c != CH_LF)
                    sc_failed = 1'b1;
                else if (!sc_crlf && sc_line_groups != 0)
                    sc_failed = 1'b1;   // CRLF after LF lines
                else
                begin
                    sc_crlf = 1'b1;
                    close_line();
                end
            PH_EOB:
                if (c != CH_PAD)
                    sc_failed = 1'b1;
                else
                begin
                    take_valid();
                    finish_pad();
                end
            default: ;
        endcase
    endfunction

    function automatic result_t predict_verdict(logic [7:0] c, logic first);
        result_t r;
        logic    ended;
        if (first)
            clear_scanner();
        if (!sc_failed && sc_phase < PH_END)
            scan_char(c);
        if (sc_seen != LEN_MAX)
            sc_seen = sc_seen + 32'd1;
        ended = (sc_phase >= PH_END);
        r.check_status      = sc_failed ? ST_FAILED : (ended ? ST_ENDED : ST_SCANNING);
        r.complete_if_ended = !sc_failed && (ended || (sc_phase == PH_G0 && sc_valid_len != 0));
        r.groups_per_line   = (sc_line_groups != 0) ? sc_line_groups : sc_cur_groups;
        r.uses_crlf         = sc_crlf;
        r.encoded_length    = sc_valid_len;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stream sides
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic first);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        expected_verdicts.push_back(predict_verdict(b, first));
    endtask

    task automatic send_text(input string s, input logic first);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], first && i == 0);
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, fname, want, got);
        end
    endtask

    initial
    begin
        result_t want;
        result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (expected_verdicts.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result item, expected none, actual %0h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    check_field("check_status", want.check_status, got.check_status);
                    check_field("complete_if_ended", want.complete_if_ended,
                                got.complete_if_ended);
                    check_field("groups_per_line", want.groups_per_line,
                                got.groups_per_line);
                    check_field("uses_crlf", want.uses_crlf, got.uses_crlf);
                    check_field("encoded_length", want.encoded_length, got.encoded_length);
                    check_field("tdata padding", '0, m_tdata[OUT_DATA_W-1:$bits(result_t)]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // random part builder
    // ------------------------------------------------------------------------
    function automatic logic [7:0] alpha_char();
        string set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        return set[$urandom_range(63)];
    endfunction

    function automatic void add_groups(ref logic [7:0] q[$], input int n);
        for (int i = 0; i < 4 * n; i++)
            q.push_back(alpha_char());
    endfunction

    function automatic void add_eol(ref logic [7:0] q[$], input bit crlf_style);
        if (crlf_style)
            q.push_back(CH_CR);
        q.push_back(CH_LF);
    endfunction

    // mostly well-formed parts; some get a corrupted byte or a flipped line end
    function automatic int build_part(ref logic [7:0] q[$]);
        int gpl;
        int nlines;
        int k;
        int useful;
        bit crlf_style;
        q.delete();
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                q.push_back(8'($urandom_range(255)));
            return q.size();
        end
        gpl        = ($urandom_range(7) == 0) ? $urandom_range(5, 19) : $urandom_range(1, 4);
        nlines     = $urandom_range(0, 4);
        crlf_style = 1'($urandom_range(1));
        for (int l = 0; l < nlines; l++)
        begin
            add_groups(q, gpl);
            add_eol(q, ($urandom_range(15) == 0) ? !crlf_style : crlf_style);
        end
        k = $urandom_range(0, gpl - 1);
        case ($urandom_range(3))
            1:
            begin
                add_groups(q, k);
                add_eol(q, crlf_style);
            end
            2:
            begin
                add_groups(q, k);
                if ($urandom_range(1))
                begin
                    q.push_back(alpha_char());
                    q.push_back(alpha_char());
                    q.push_back(CH_PAD);
                end
                else
                begin
                    repeat (3)
                        q.push_back(alpha_char());
                end
                q.push_back(CH_PAD);
                if ($urandom_range(1))
                    add_eol(q, crlf_style);
            end
            3:
            begin
                add_groups(q, k);
                repeat ($urandom_range(0, 3))
                    q.push_back(alpha_char());
            end
            default: ;
        endcase
        if (q.size() == 0)
            q.push_back(alpha_char());
        useful = q.size();
        if ($urandom_range(3) == 0)
            q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
        if ($urandom_range(1))
        begin
            repeat ($urandom_range(1, 3))
                q.push_back(8'($urandom_range(255)));
        end
        return useful;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_layouts();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_text("Az09", 1'b1);
        send_text("+/==", 1'b0);        // two pad chars end the data
        send_byte(8'hFF, 1'b0);         // ignored after end
        send_byte(CH_LF, 1'b1);         // empty first line
        send_byte(8'h00, 1'b0);
        send_text("AAAA\r\n\n", 1'b1);  // bare LF after CRLF lines
        send_text("AAAA\n\r\n", 1'b1);  // CRLF after LF lines
        send_text("A=", 1'b1);          // pad in second position
    endtask

    task automatic test_random_parts(input int target, input int s_idle, input int r_stall);
        logic [7:0] part[$];
        int sent;
        int useful;
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        sent = 0;
        while (sent < target)
        begin
            useful = build_part(part);
            for (int i = 0; i < part.size(); i++)
                send_byte(part[i], (i == 0) ? ($urandom_range(15) != 0) : 1'b0);
            sent += useful;
        end
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_layouts();
        test_random_parts(500, 0, 0);
        test_random_parts(500, 66, 0);
        test_random_parts(500, 0, 66);
        test_random_parts(500, 13, 13);

        @(negedge clk);
        s_tvalid       <= 1'b0;
        recv_stall_pct = 0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
hdl/b64lc_pkg.sv
hdl/b64lc_scan.sv
hdl/base64_layout_checker_top.sv
sim/base64_layout_checker_top_tb.sv
